// ===== hdl/sse_pkg.sv =====
// Shared types, character codes and the per-byte line parser for the SSE deframer.
package sse_pkg;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;

    localparam logic [2:0] PREFIX_LEN = 3'd5;
    localparam logic [2:0] POS_SAT    = 3'd6;

    localparam logic [1:0] KIND_PREFIX = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_IGNORE = 2'd2;

    typedef struct packed {
        logic [2:0] pos;
        logic [1:0] kind;
        logic       has_bytes;
    } line_state_t;

    typedef struct packed {
        line_state_t st;
        logic        emit;
        logic [7:0]  data;
    } content_t;

    typedef struct packed {
        logic [7:0] data;
        logic       event_end;
        logic       last;
    } result_t;

    // Expected character of "data:" at a given prefix position.
    function automatic logic [7:0] prefix_char(logic [2:0] p);
        logic [7:0] ch;
        case (p)
            3'd0:    ch = 8'h64;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] bump(logic [2:0] p);
        return (p < POS_SAT) ? p + 3'd1 : p;
    endfunction

    // One content byte of a line (anything but the terminating LF).
    function automatic content_t content_byte(logic [7:0] c, line_state_t st);
        content_t r;
        r.st   = st;
        r.emit = 1'b0;
        r.data = c;
        case (st.kind)
            KIND_PREFIX: begin
                if (st.pos < PREFIX_LEN && c == prefix_char(st.pos)) begin
                    r.st.pos = bump(st.pos);
                    if (r.st.pos == PREFIX_LEN) begin
                        r.st.kind = KIND_DATA;
                        // separator only once the event holds bytes
                        r.emit    = st.has_bytes;
                        r.data    = CH_LF;
                    end
                end else begin
                    r.st.kind = KIND_IGNORE;
                    r.st.pos  = bump(st.pos);
                end
            end
            KIND_DATA: begin
                if (st.pos <= PREFIX_LEN) begin
                    // first value byte: optional space is dropped
                    r.st.pos = POS_SAT;
                    if (c != CH_SP) begin
                        r.emit         = 1'b1;
                        r.st.has_bytes = 1'b1;
                    end
                end else begin
                    r.emit         = 1'b1;
                    r.st.has_bytes = 1'b1;
                end
            end
            default: begin
                r.st.pos = bump(st.pos);
            end
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/sse_event_data_deframer.sv =====
// Top level of the SSE deframer: input register, per-byte parser, two-entry result buffer.
//
//  channel | direction | ports                                        | carries
//  s_      | in        | s_valid s_ready s_in_byte                    | raw stream byte
//  m_      | out       | m_valid m_ready m_out_byte m_is_event_end    | payload byte or
//          |           | m_last_of_run                                | event-end marker
//
// One byte per cycle while m_ready is high and each byte yields at most one result;
// a byte that yields two results (held CR plus next byte) holds the result buffer
// until both are taken. Input bytes pass the input register, then the result buffer.
// Reset (aresetn low, synchronous) clears line state, held CR and all valid flags.
// Stalls on m_ready back up through the input register to s_ready.
module sse_event_data_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_event_end,
    output logic       m_last_of_run
);
    import sse_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    line_state_t st_reg, st_next;
    logic        held_cr_reg, held_cr_next;
    result_t     slot0_reg, slot1_reg;
    logic [1:0]  cnt_reg;

    logic        drain;
    logic        proceed;
    content_t    a_res, b_res;
    result_t     r0, r1;
    logic [1:0]  n_res;

    assign m_valid        = (cnt_reg != 2'd0);
    assign m_out_byte     = slot0_reg.data;
    assign m_is_event_end = slot0_reg.event_end;
    assign m_last_of_run  = slot0_reg.last;

    // buffer is free for a new transaction's results this cycle
    assign drain   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign proceed = in_valid_reg && drain;
    assign s_ready = !in_valid_reg || proceed;

    always_comb begin
        a_res        = '{st: st_reg, emit: 1'b0, data: CH_CR};
        b_res        = '{st: st_reg, emit: 1'b0, data: 8'h00};
        held_cr_next = held_cr_reg;
        st_next      = st_reg;
        r0           = '{data: 8'h00, event_end: 1'b0, last: 1'b1};
        r1           = '{data: 8'h00, event_end: 1'b0, last: 1'b1};
        n_res        = 2'd0;

        if (in_byte_reg == CH_LF) begin
            held_cr_next = 1'b0;
            if (st_reg.kind == KIND_PREFIX && st_reg.pos == 3'd0) begin
                if (st_reg.has_bytes) begin
                    r0.event_end = 1'b1;
                    n_res        = 2'd1;
                end
                st_next.has_bytes = 1'b0;
            end
            st_next.pos  = 3'd0;
            st_next.kind = KIND_PREFIX;
        end else begin
            // a held CR that is not followed by LF is line content
            if (held_cr_reg) begin
                a_res = content_byte(CH_CR, st_reg);
            end
            b_res.st = a_res.st;
            if (in_byte_reg == CH_CR) begin
                held_cr_next = 1'b1;
            end else begin
                held_cr_next = 1'b0;
                b_res        = content_byte(in_byte_reg, a_res.st);
            end
            st_next = b_res.st;

            if (a_res.emit) begin
                r0.data = a_res.data;
                r0.last = !b_res.emit;
                r1.data = b_res.data;
                n_res   = b_res.emit ? 2'd2 : 2'd1;
            end else begin
                r0.data = b_res.data;
                n_res   = b_res.emit ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            st_reg       <= '{pos: 3'd0, kind: KIND_PREFIX, has_bytes: 1'b0};
            held_cr_reg  <= 1'b0;
            cnt_reg      <= 2'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proceed) begin
                st_reg      <= st_next;
                held_cr_reg <= held_cr_next;
                cnt_reg     <= n_res;
            end else if (m_valid && m_ready) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
        if (proceed) begin
            slot0_reg <= r0;
            slot1_reg <= r1;
        end else if (m_valid && m_ready) begin
            slot0_reg <= slot1_reg;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_marker_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_event_end |-> m_out_byte == 8'h00 && m_last_of_run)
        else $error("event-end marker malformed");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !slot0_reg.last && slot1_reg.last)
        else $error("two-result run has wrong last flags");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !proceed)
        else $error("new transaction processed while buffer full");

endmodule
